// ===== src/nco_pkg.sv =====
// Shared types and constants for the natural coefficient order generator.
`timescale 1ns / 1ps
`default_nettype none

package nco_pkg;

  // Smallest block side is 8, so the low-frequency corner is side / 8.
  localparam logic [2:0] WLOG_MIN = 3'd3;
  localparam logic [2:0] WLOG_CAP = 3'd7;
  localparam logic [2:0] LF_SHIFT = 3'd3;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // latch shape, restart if requested
    logic step;          // evaluate one scan candidate
    logic emit_direct;   // load output register from the current step result
    logic capture;       // park the current step result
    logic emit_pending;  // load output register from the parked result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;          // current step produced the entry
  } sts_t;

endpackage

`default_nettype wire

// ===== src/nco_ctrl.sv =====
// Controller state machine: input and output handshakes and step sequencing.
`timescale 1ns / 1ps
`default_nettype none

module nco_ctrl import nco_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          if (out_free) begin
            cmd_o.emit_direct = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd_o.emit_pending = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit_direct || cmd_o.emit_pending) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/nco_dp.sv =====
// Datapath: shape and scan state, one-candidate diagonal walker, result registers.
`timescale 1ns / 1ps
`default_nettype none

module nco_dp import nco_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  wire logic        start_req_i,
  input  wire logic [2:0]  width_log2_i,
  input  wire logic [2:0]  height_log2_i,
  output logic [6:0]       coord_x_o,
  output logic [6:0]       coord_y_o,
  output logic [13:0]      position_o,
  output logic             last_o
);

  localparam int unsigned FloorLog2 = $clog2(MAX_DIM + 1) - 1;
  localparam logic [2:0]  MaxWLog2  = (FloorLog2 > 7) ? WLOG_CAP : 3'(FloorLog2);

  // Scan state
  logic [2:0]  wl_q, ratio_q;
  logic        in_diag_q, wrap_q;
  logic [8:0]  diag_q;
  logic [7:0]  offs_q;
  logic [14:0] count_q;

  // Load-time shape selection
  logic [2:0]  w_cl, h_cl, w_n, r_n;
  logic [14:0] cnt_n, total_n;
  logic        restart_n;

  always_comb begin
    if (width_log2_i < WLOG_MIN)      w_cl = WLOG_MIN;
    else if (width_log2_i > MaxWLog2) w_cl = MaxWLog2;
    else                              w_cl = width_log2_i;
    if (height_log2_i < WLOG_MIN)     h_cl = WLOG_MIN;
    else if (height_log2_i > w_cl)    h_cl = w_cl;
    else                              h_cl = height_log2_i;
    w_n       = start_req_i ? w_cl : wl_q;
    r_n       = start_req_i ? (w_cl - h_cl) : ratio_q;
    cnt_n     = start_req_i ? '0 : count_q;
    total_n   = 15'(1) << (4'(w_n) + 4'(w_n) - 4'(r_n));
    restart_n = start_req_i || (cnt_n >= total_n);
  end

  // Per-step evaluation on the latched shape
  logic [2:0]  h_l;
  logic [14:0] total, pos_inc, lf_total;
  logic        is_last, lf_end;
  logic [8:0]  bw, lbw, margin, kk, lim, dm1k, cx, cy, mask;
  logic [9:0]  tbw;
  logic        d_wrap, next_diag, in_corner, row_skip;
  logic [6:0]  lf_x, lf_y, walk_y;

  always_comb begin
    h_l      = wl_q - ratio_q;
    total    = 15'(1) << (4'(wl_q) + 4'(h_l));
    pos_inc  = count_q + 15'd1;
    is_last  = (pos_inc == total);
    lbw      = 9'(1) << (wl_q - LF_SHIFT);
    lf_total = 15'(1) << (4'(wl_q - LF_SHIFT) + 4'(h_l - LF_SHIFT));
    lf_end   = (pos_inc >= lf_total);
    lf_x     = 7'(count_q & 15'(lbw - 9'd1));
    lf_y     = 7'(count_q >> (wl_q - LF_SHIFT));

    bw        = 9'(1) << wl_q;
    tbw       = 10'(1) << (4'(wl_q) + 4'd1);
    d_wrap    = ({1'b0, diag_q} >= tbw);
    margin    = (diag_q > bw) ? (diag_q - bw) : 9'd0;
    kk        = ({1'b0, offs_q} < margin) ? margin : {1'b0, offs_q};
    lim       = diag_q - margin;
    next_diag = (kk >= lim);
    dm1k      = diag_q - 9'd1 - kk;
    // Odd diagonals run with x rising, even ones with x falling
    cx        = diag_q[0] ? kk : dm1k;
    cy        = diag_q[0] ? dm1k : kk;
    in_corner = (cx < lbw) && (cy < lbw);
    mask      = (9'(1) << ratio_q) - 9'd1;
    row_skip  = |(cy & mask);
    walk_y    = 7'(cy >> ratio_q);
  end

  logic       done, id_n, wr_n;
  logic [8:0] d_n;
  logic [7:0] k_n;
  logic [6:0] rx, ry;

  always_comb begin
    done = 1'b0;
    rx   = '0;
    ry   = '0;
    d_n  = diag_q;
    k_n  = offs_q;
    id_n = in_diag_q;
    wr_n = wrap_q;
    if (!in_diag_q) begin
      done = 1'b1;
      rx   = lf_x;
      ry   = lf_y;
      if (lf_end) begin
        id_n = 1'b1;
        d_n  = 9'd1;
        k_n  = '0;
      end
    end else if (d_wrap) begin
      d_n = 9'd1;
      k_n = '0;
      if (wrap_q) done = 1'b1;
      else        wr_n = 1'b1;
    end else if (next_diag) begin
      d_n = diag_q + 9'd1;
      k_n = '0;
    end else begin
      k_n = 8'(kk + 9'd1);
      if (!in_corner && !row_skip) begin
        done = 1'b1;
        rx   = 7'(cx);
        ry   = walk_y;
      end
    end
  end

  assign sts_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q      <= WLOG_MIN;
      ratio_q   <= '0;
      in_diag_q <= 1'b0;
      wrap_q    <= 1'b0;
      diag_q    <= 9'd1;
      offs_q    <= '0;
      count_q   <= '0;
    end else if (cmd_i.load) begin
      wl_q    <= w_n;
      ratio_q <= r_n;
      wrap_q  <= 1'b0;
      if (restart_n) begin
        in_diag_q <= 1'b0;
        diag_q    <= 9'd1;
        offs_q    <= '0;
        count_q   <= '0;
      end
    end else if (cmd_i.step) begin
      in_diag_q <= id_n;
      wrap_q    <= wr_n;
      diag_q    <= d_n;
      offs_q    <= k_n;
      if (done) begin
        if (is_last) begin
          in_diag_q <= 1'b0;
          diag_q    <= 9'd1;
          offs_q    <= '0;
          count_q   <= '0;
        end else begin
          count_q <= pos_inc;
        end
      end
    end
  end

  // Result payload: parked copy and output register
  logic [6:0]  pend_x_q, pend_y_q;
  logic [13:0] pend_pos_q;
  logic        pend_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pend_x_q    <= rx;
      pend_y_q    <= ry;
      pend_pos_q  <= count_q[13:0];
      pend_last_q <= is_last;
    end
    if (cmd_i.emit_direct) begin
      coord_x_o  <= rx;
      coord_y_o  <= ry;
      position_o <= count_q[13:0];
      last_o     <= is_last;
    end else if (cmd_i.emit_pending) begin
      coord_x_o  <= pend_x_q;
      coord_y_o  <= pend_y_q;
      position_o <= pend_pos_q;
      last_o     <= pend_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== src/natural_coeff_order_gen_unit.sv =====
// Top level of the natural coefficient scan order generator.
// Low-frequency entries are accepted (ST_IDLE) and then evaluated (ST_CALC).
// Diagonal entries also step over every skipped candidate, diagonal end and
// grid wrap; the walker tests one candidate position per cycle.
// Throughput: one item in flight; the next transfer is taken once the result
// sits in the output register.
// Reset (rst_ni, async, low): 8x8 shape, order restarts at entry 0, no output.
`timescale 1ns / 1ps
`default_nettype none

module natural_coeff_order_gen_unit import nco_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [2:0] width_log2, [5:3] height_log2
  input  wire logic                   s_axis_tuser,  // [0] start_req
  // Coordinate stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [6:0] coord_x, [13:7] coord_y,
                                                     // [27:14] position
  output logic                        m_axis_tlast   // last
);

  cmd_t        cmd;
  sts_t        sts;
  logic [6:0]  coord_x, coord_y;
  logic [13:0] position;

  // Sequence accept, step and result hand-off
  nco_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold shape and scan position, walk diagonals, register results
  nco_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_req_i   (s_axis_tuser),
    .width_log2_i  (s_axis_tdata[2:0]),
    .height_log2_i (s_axis_tdata[5:3]),
    .coord_x_o     (coord_x),
    .coord_y_o     (coord_y),
    .position_o    (position),
    .last_o        (m_axis_tlast)
  );

  // Pack result fields, pad to whole bytes with zeros
  assign m_axis_tdata = {4'd0, position, coord_y, coord_x};

endmodule

`default_nettype wire
